// File: rtl/u2p_pkg.sv
// shared types and constants for the uyvy to p010 converter
`default_nettype none

package u2p_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MACROPIXELS_PER_LINE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_PAIRS_PER_FRAME = 1'b1;

   // configuration data and reset values
   localparam int CSR_DATA_W = 12;
   localparam logic [CSR_DATA_W-1:0] MACROPIXELS_RESET = 12'd960;
   localparam logic [CSR_DATA_W-1:0] LINE_PAIRS_RESET  = 12'd540;

   // field widths
   localparam int SAMPLE_W = 8;
   localparam int WORD_W   = 16;
   localparam int ROW_W    = 12;
   localparam int COLUMN_W = 11;

   typedef logic [SAMPLE_W-1:0]    sample_type;
   typedef logic [WORD_W-1:0]      word_type;
   typedef logic [ROW_W-1:0]       row_type;
   typedef logic [COLUMN_W-1:0]    column_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   // widen an 8-bit sample to a p010 word
   function automatic word_type to_p010(input sample_type s);
      to_p010 = {s, {(WORD_W - SAMPLE_W){1'b0}}};
   endfunction

endpackage

`default_nettype wire

// File: rtl/u2p_if.sv
// request, response and register write channels of the converter
`default_nettype none

interface u2p_req_if;
   import u2p_pkg::*;
   logic       valid;
   logic       ready;
   sample_type chroma_u_in;
   sample_type luma_first_in;
   sample_type chroma_v_in;
   sample_type luma_second_in;
   modport source (output valid, chroma_u_in, luma_first_in, chroma_v_in, luma_second_in,
                   input ready);
   modport sink   (input valid, chroma_u_in, luma_first_in, chroma_v_in, luma_second_in,
                   output ready);
endinterface

interface u2p_rsp_if;
   import u2p_pkg::*;
   logic       valid;
   logic       ready;
   word_type   luma_first_out;
   word_type   luma_second_out;
   logic       chroma_valid;
   word_type   chroma_u_out;
   word_type   chroma_v_out;
   row_type    row_index;
   column_type pair_column;
   logic       frame_end;
   modport source (output valid, luma_first_out, luma_second_out, chroma_valid,
                   chroma_u_out, chroma_v_out, row_index, pair_column, frame_end,
                   input ready);
   modport sink   (input valid, luma_first_out, luma_second_out, chroma_valid,
                   chroma_u_out, chroma_v_out, row_index, pair_column, frame_end,
                   output ready);
endinterface

interface u2p_csr_if;
   import u2p_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type reg_index;
   csr_data_type  write_data;
   modport source (output valid, reg_index, write_data, input ready);
   modport sink   (input valid, reg_index, write_data, output ready);
endinterface

`default_nettype wire

// File: rtl/uyvy_to_p010_converter.sv
// uyvy 4:2:2 macropixel stream to p010 4:2:0 words with vertical chroma averaging
`default_nettype none

// Takes one UYVY macropixel per request in raster order and returns one result per
// request, at a sustained rate of one request per clock while responses are taken.
// Accepting a request registers it and reads the chroma line buffer (one address
// port, registered read data); the averaged chroma then loads the result register,
// which frees the request side while a response waits. Even lines store U/V by
// column, odd lines average with the stored pair. The user must write both size
// registers only while idle; the block does not enforce this. 0 acts as 1 and
// values above the parameter limits are clamped. The buffer holds MAX_PAIRS_PER_LINE
// entries with no reset, so an odd line must follow an even line of the same width.
module uyvy_to_p010_converter #(
   parameter int MAX_PAIRS_PER_LINE = 2048,
   parameter int MAX_LINE_PAIRS     = 2048
) (
   input  wire logic clock,
   input  wire logic reset,
   u2p_req_if.sink   req_chan,
   u2p_rsp_if.source rsp_chan,
   u2p_csr_if.sink   csr_chan
);
   import u2p_pkg::*;

   localparam int CW = (MAX_PAIRS_PER_LINE > 1) ? $clog2(MAX_PAIRS_PER_LINE) : 1;
   localparam int HW = (MAX_LINE_PAIRS > 1) ? $clog2(MAX_LINE_PAIRS) : 1;
   localparam int WW = ($clog2(MAX_PAIRS_PER_LINE + 1) > CSR_DATA_W) ?
                       $clog2(MAX_PAIRS_PER_LINE + 1) : CSR_DATA_W;
   localparam int HH = ($clog2(MAX_LINE_PAIRS + 1) > CSR_DATA_W) ?
                       $clog2(MAX_LINE_PAIRS + 1) : CSR_DATA_W;
   localparam int RW = (HW + 1 > ROW_W) ? HW + 1 : ROW_W;
   localparam int PW = (CW > COLUMN_W) ? CW : COLUMN_W;

   // configuration registers
   csr_data_type width_cfg_ff, height_cfg_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= MACROPIXELS_RESET;
         height_cfg_ff <= LINE_PAIRS_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.reg_index)
            CSR_MACROPIXELS_PER_LINE: width_cfg_ff  <= csr_chan.write_data;
            CSR_LINE_PAIRS_PER_FRAME: height_cfg_ff <= csr_chan.write_data;
            default: ;
         endcase
      end
   end

   // clamped frame size
   logic [WW-1:0] width_ext, width_eff;
   logic [HH-1:0] height_ext, height_eff;

   always_comb begin
      width_ext  = WW'(width_cfg_ff);
      height_ext = HH'(height_cfg_ff);
      if (width_ext == '0) width_eff = WW'(1);
      else if (width_ext > WW'(MAX_PAIRS_PER_LINE)) width_eff = WW'(MAX_PAIRS_PER_LINE);
      else width_eff = width_ext;
      if (height_ext == '0) height_eff = HH'(1);
      else if (height_ext > HH'(MAX_LINE_PAIRS)) height_eff = HH'(MAX_LINE_PAIRS);
      else height_eff = height_ext;
   end

   // pipeline handshake
   logic s1_valid_ff, out_valid_ff;
   logic s1_adv, req_accept;

   assign s1_adv         = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // raster position counters
   logic [CW-1:0] col_ff, col_in;
   logic [HW-1:0] pair_ff, pair_in;
   logic          odd_ff, odd_in;
   logic [WW-1:0] col_inc;
   logic [HH-1:0] pair_inc;
   logic          col_wrap, pair_wrap, frame_end_in;

   always_comb begin
      col_inc      = WW'(col_ff) + WW'(1);
      pair_inc     = HH'(pair_ff) + HH'(1);
      col_wrap     = col_inc >= width_eff;
      pair_wrap    = pair_inc >= height_eff;
      frame_end_in = odd_ff && (col_inc == width_eff) && (pair_inc == height_eff);
      col_in       = col_wrap ? '0 : col_inc[CW-1:0];
      odd_in       = odd_ff;
      pair_in      = pair_ff;
      if (col_wrap) begin
         odd_in = !odd_ff;
         if (odd_ff) pair_in = pair_wrap ? '0 : pair_inc[HW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         pair_ff <= '0;
         odd_ff  <= 1'b0;
      end else if (req_accept) begin
         col_ff  <= col_in;
         pair_ff <= pair_in;
         odd_ff  <= odd_in;
      end
   end

   // chroma line buffer: write on even lines, read data used on odd lines
   logic [2*SAMPLE_W-1:0] line_mem [MAX_PAIRS_PER_LINE];
   logic [2*SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (!odd_ff) line_mem[col_ff] <= {req_chan.chroma_v_in, req_chan.chroma_u_in};
         rd_data_ff <= line_mem[col_ff];
      end
   end

   // first stage register
   sample_type s1_u_ff, s1_v_ff, s1_y0_ff, s1_y1_ff;
   logic       s1_odd_ff, s1_fend_ff;
   row_type    s1_row_ff;
   column_type s1_col_ff;
   logic [RW-1:0] row_ext;
   logic [PW-1:0] col_ext;

   assign row_ext = (RW'(pair_ff) << 1) | RW'(odd_ff);
   assign col_ext = PW'(col_ff);

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (req_accept) s1_valid_ff <= 1'b1;
      else if (s1_adv) s1_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_u_ff    <= req_chan.chroma_u_in;
         s1_v_ff    <= req_chan.chroma_v_in;
         s1_y0_ff   <= req_chan.luma_first_in;
         s1_y1_ff   <= req_chan.luma_second_in;
         s1_odd_ff  <= odd_ff;
         s1_fend_ff <= frame_end_in;
         s1_row_ff  <= row_ext[ROW_W-1:0];
         s1_col_ff  <= col_ext[COLUMN_W-1:0];
      end
   end

   // vertical chroma average, rounding half up
   logic [SAMPLE_W:0] u_sum, v_sum;
   word_type          u_out_in, v_out_in;

   always_comb begin
      u_sum = {1'b0, rd_data_ff[SAMPLE_W-1:0]} + {1'b0, s1_u_ff} + (SAMPLE_W+1)'(1);
      v_sum = {1'b0, rd_data_ff[2*SAMPLE_W-1:SAMPLE_W]} + {1'b0, s1_v_ff}
              + (SAMPLE_W+1)'(1);
      u_out_in = s1_odd_ff ? to_p010(u_sum[SAMPLE_W:1]) : '0;
      v_out_in = s1_odd_ff ? to_p010(v_sum[SAMPLE_W:1]) : '0;
   end

   // result register
   word_type   y0_out_ff, y1_out_ff, u_out_ff, v_out_ff;
   logic       cvalid_ff, fend_ff;
   row_type    row_ff;
   column_type colout_ff;

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (s1_adv) out_valid_ff <= 1'b1;
      else if (rsp_chan.ready) out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         y0_out_ff <= to_p010(s1_y0_ff);
         y1_out_ff <= to_p010(s1_y1_ff);
         u_out_ff  <= u_out_in;
         v_out_ff  <= v_out_in;
         cvalid_ff <= s1_odd_ff;
         fend_ff   <= s1_fend_ff;
         row_ff    <= s1_row_ff;
         colout_ff <= s1_col_ff;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.luma_first_out  = y0_out_ff;
   assign rsp_chan.luma_second_out = y1_out_ff;
   assign rsp_chan.chroma_valid    = cvalid_ff;
   assign rsp_chan.chroma_u_out    = u_out_ff;
   assign rsp_chan.chroma_v_out    = v_out_ff;
   assign rsp_chan.row_index       = row_ff;
   assign rsp_chan.pair_column     = colout_ff;
   assign rsp_chan.frame_end       = fend_ff;

   // checks
   a_chroma_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !cvalid_ff |-> u_out_ff == '0 && v_out_ff == '0)
      else $error("chroma not zero on even line");

   a_fend_odd: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && fend_ff |-> cvalid_ff)
      else $error("frame end on even line");

   a_row_parity: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> row_ff[0] == cvalid_ff)
      else $error("row parity does not match chroma flag");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff)
      else $error("stalled request dropped");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      WW'(col_ff) < WW'(MAX_PAIRS_PER_LINE))
      else $error("column counter beyond buffer");

endmodule

`default_nettype wire
